>>> hdl/ookpwe_pkg.sv
// ----------------------------------------------------------------------------
// ookpwe_pkg
// Types, constants and register indexes shared by the OOK pulse-width encoder.
// ----------------------------------------------------------------------------
package ookpwe_pkg;

  localparam int RUN_WIDTH_DEF = 6;

  localparam logic [3:0]  BYTE_CHIPS = 4'd8;
  localparam logic [19:0] TOTAL_MAX  = 20'hFFFFF;

  // configuration register indexes
  localparam logic [2:0] REG_HIGH_FIRST = 3'd0;
  localparam logic [2:0] REG_START_LEN  = 3'd1;
  localparam logic [2:0] REG_END_LEN    = 3'd2;
  localparam logic [2:0] REG_ZERO_LEN   = 3'd3;
  localparam logic [2:0] REG_ONE_LEN    = 3'd4;

  // run phases: two runs for each of the start, data and end symbols
  localparam logic [2:0] PH_START_A = 3'd0;
  localparam logic [2:0] PH_START_B = 3'd1;
  localparam logic [2:0] PH_DATA_A  = 3'd2;
  localparam logic [2:0] PH_DATA_B  = 3'd3;
  localparam logic [2:0] PH_END_A   = 3'd4;
  localparam logic [2:0] PH_END_B   = 3'd5;

  // symbol selected by the upper two phase bits
  localparam logic [1:0] SYM_START = 2'd0;
  localparam logic [1:0] SYM_DATA  = 2'd1;
  localparam logic [1:0] SYM_END   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic data_bit;
    logic first_bit;
    logic last_bit;
  } in_t;

  typedef struct packed {
    logic [7:0]  raw_byte;
    logic [3:0]  valid_chips;
    logic        last_byte;
    logic [19:0] frame_length;
  } out_t;

  // packer state handed to the shift unit
  typedef struct packed {
    logic [7:0]  acc;
    logic [2:0]  fill;
    logic [19:0] total;
    logic        chip;
  } pack_req_t;

  // packer result: fill may reach eight, chunk is the number of chips taken
  typedef struct packed {
    logic [7:0]  acc;
    logic [3:0]  fill;
    logic [19:0] total;
    logic [3:0]  chunk;
  } pack_res_t;

endpackage

>>> hdl/ook_pulse_width_encoder_unit.sv
// ----------------------------------------------------------------------------
// ook_pulse_width_encoder_unit
// OOK pulse-width encoder: data bits to MSB-first packed chip bytes.
// ----------------------------------------------------------------------------
// Each accepted bit is expanded into runs of high and low chips (start symbol
// before a first bit, end symbol after a last bit) which a shared shift unit
// packs into bytes, up to eight chips per cycle while a held byte can move on
// to the output. Each of an item's two, four or six runs is loaded and then
// closed, a non-empty run is cut into chunks at byte boundaries, and a flush
// then sends the held byte and, at a frame's end, the remainder. A completed
// byte is held back one chunk so that the final byte of a frame can carry
// last_byte; the input stalls until the item's bytes have all moved into the
// output register.
module ook_pulse_width_encoder_unit import ookpwe_pkg::*; #(
  parameter int RUN_WIDTH = RUN_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [2*RUN_WIDTH-1:0] cfg_data
);

  localparam int LW = 2 * RUN_WIDTH;

  // configuration
  logic          high_first_r;
  logic [LW-1:0] start_len_r, end_len_r, zero_len_r, one_len_r;

  // sequencer and packing state
  state_t                 state_r, state_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic                   data_r, data_nxt;
  logic                   last_r, last_nxt;
  logic                   chip_r, chip_nxt;
  logic [RUN_WIDTH-1:0]   run_left_r, run_left_nxt;
  logic [7:0]             acc_r, acc_nxt;
  logic [2:0]             fill_r, fill_nxt;
  logic [19:0]            total_r, total_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [7:0]             pend_byte_r, pend_byte_nxt;
  logic [19:0]            pend_total_r, pend_total_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_r, out_nxt;

  logic          in_fire, out_free;
  logic [LW-1:0] sym_len;
  logic          run_chip;
  pack_req_t     pk_req;
  pack_res_t     pk_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_first_r <= 1'b1;
      start_len_r  <= '0;
      end_len_r    <= '0;
      zero_len_r   <= '0;
      one_len_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH_FIRST: high_first_r <= cfg_data[0];
        REG_START_LEN:  start_len_r  <= cfg_data;
        REG_END_LEN:    end_len_r    <= cfg_data;
        REG_ZERO_LEN:   zero_len_r   <= cfg_data;
        REG_ONE_LEN:    one_len_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // lengths of the symbol in the current phase, and the run's chip value
  always_comb begin
    unique case (phase_r[2:1])
      SYM_START: sym_len = start_len_r;
      SYM_DATA:  sym_len = data_r ? one_len_r : zero_len_r;
      SYM_END:   sym_len = end_len_r;
      default:   sym_len = '0;
    endcase
    run_chip = phase_r[0] ? !high_first_r : high_first_r;
  end

  assign pk_req = '{acc: acc_r, fill: fill_r, total: total_r, chip: chip_r};

  ookpwe_packer #(.RUN_WIDTH(RUN_WIDTH)) u_packer (
    .req      (pk_req),
    .run_left (run_left_r),
    .res      (pk_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_START_A;
      acc_r       <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r       <= data_nxt;
    last_r       <= last_nxt;
    chip_r       <= chip_nxt;
    run_left_r   <= run_left_nxt;
    pend_byte_r  <= pend_byte_nxt;
    pend_total_r <= pend_total_nxt;
    out_r        <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    data_nxt       = data_r;
    last_nxt       = last_r;
    chip_nxt       = chip_r;
    run_left_nxt   = run_left_r;
    acc_nxt        = acc_r;
    fill_nxt       = fill_r;
    total_nxt      = total_r;
    pend_v_nxt     = pend_v_r;
    pend_byte_nxt  = pend_byte_r;
    pend_total_nxt = pend_total_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          data_nxt = in_data.data_bit;
          last_nxt = in_data.last_bit;
          if (in_data.first_bit) begin
            acc_nxt   = '0;
            fill_nxt  = '0;
            total_nxt = '0;
            phase_nxt = PH_START_A;
          end else begin
            phase_nxt = PH_DATA_A;
          end
          state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        chip_nxt     = run_chip;
        run_left_nxt = run_chip ? sym_len[LW-1:RUN_WIDTH] : sym_len[RUN_WIDTH-1:0];
        state_nxt    = ST_RUN;
      end

      ST_RUN: begin
        if (run_left_r == '0) begin
          if ((phase_r == PH_DATA_B && !last_r) || phase_r == PH_END_B) begin
            state_nxt = ST_FLUSH;
          end else begin
            phase_nxt = phase_r + 3'd1;
            state_nxt = ST_LOAD;
          end
        end else if (!pend_v_r || out_free) begin
          run_left_nxt = run_left_r - RUN_WIDTH'(pk_res.chunk);
          total_nxt    = pk_res.total;
          // more chips follow the held byte, so it cannot be the last one
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{raw_byte: pend_byte_r, valid_chips: BYTE_CHIPS,
                              last_byte: 1'b0, frame_length: pend_total_r};
            pend_v_nxt    = 1'b0;
          end
          if (pk_res.fill == BYTE_CHIPS) begin
            pend_v_nxt     = 1'b1;
            pend_byte_nxt  = pk_res.acc;
            pend_total_nxt = pk_res.total;
            acc_nxt        = '0;
            fill_nxt       = '0;
          end else begin
            acc_nxt  = pk_res.acc;
            fill_nxt = pk_res.fill[2:0];
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          priority if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{raw_byte: pend_byte_r, valid_chips: BYTE_CHIPS,
                              last_byte: last_r && (fill_r == '0),
                              frame_length: pend_total_r};
            pend_v_nxt    = 1'b0;
            if (!last_r || fill_r == '0) begin
              state_nxt = ST_IDLE;
            end
            if (last_r && fill_r == '0) begin
              acc_nxt   = '0;
              total_nxt = '0;
            end
          end else if (!last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            // remainder, or an empty marker when nothing is left
            out_valid_nxt = 1'b1;
            out_nxt       = '{raw_byte: 8'(acc_r << (BYTE_CHIPS - {1'b0, fill_r})),
                              valid_chips: {1'b0, fill_r}, last_byte: 1'b1,
                              frame_length: total_r};
            acc_nxt       = '0;
            fill_nxt      = '0;
            total_nxt     = '0;
            state_nxt     = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // held byte never outlives its item
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_v_r)
    else $error("held byte left over after item");

  // a short byte only ever closes a frame
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.valid_chips != BYTE_CHIPS |-> out_r.last_byte)
    else $error("partial byte without last_byte");

  // a frame close leaves the packer empty
  a_close_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r && out_r.last_byte) |-> fill_r == '0 && total_r == '0)
    else $error("packer state not cleared at frame end");

  // the packer never takes chips while a held byte cannot move on
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && pend_v_r && !out_free |=> $stable(run_left_r))
    else $error("chips packed over a blocked held byte");

endmodule

>>> hdl/ookpwe_packer.sv
// ----------------------------------------------------------------------------
// ookpwe_packer
// Shift unit: moves a chunk of identical chips into the byte accumulator,
// as many as the run has left or the byte has room for, and counts them.
// ----------------------------------------------------------------------------
module ookpwe_packer import ookpwe_pkg::*; #(
  parameter int RUN_WIDTH = RUN_WIDTH_DEF
) (
  input  pack_req_t              req,
  input  logic [RUN_WIDTH-1:0]   run_left,
  output pack_res_t              res
);

  localparam int CW = (RUN_WIDTH > 4) ? RUN_WIDTH : 4;

  logic [3:0]  room;
  logic [3:0]  chunk;
  logic [15:0] shifted;
  logic [8:0]  ones;
  logic [20:0] sum;

  always_comb begin
    room = BYTE_CHIPS - {1'b0, req.fill};
    if (CW'(run_left) < CW'(room)) begin
      chunk = 4'(run_left);
    end else begin
      chunk = room;
    end
    shifted = {8'd0, req.acc} << chunk;
    ones    = (9'd1 << chunk) - 9'd1;
    sum     = {1'b0, req.total} + 21'(chunk);

    res.chunk = chunk;
    res.acc   = shifted[7:0] | (req.chip ? ones[7:0] : 8'd0);
    res.fill  = {1'b0, req.fill} + chunk;
    // saturate the frame length
    res.total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[19:0];
  end

endmodule
